// File: rtl/next_fit_heap_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// next_fit_heap_allocator_core_macros
// assertion macros used by the allocator core
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define NEXT_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define NFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define NFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define NFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/nfa_pkg.sv
// ----------------------------------------------------------------------------
// nfa_pkg
// shared types and constants of the next-fit heap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package nfa_pkg;

	localparam int WORD_BYTES  = 4;
	localparam int DWORD_BYTES = 8;
	localparam int MIN_BLOCK   = 16;
	localparam int FLAG_BITS   = 7;
	localparam int PRO_TAG     = 9;
	localparam int EPI_TAG     = 1;
	localparam int LAYOUT_END  = 16;
	localparam int FIRST_BP    = 8;
	localparam int MIN_CHUNK   = 8;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OOM  = 2'd2;

	typedef enum logic [5:0] {
		U_NOP, U_ACCEPT, U_F_RD, U_F_SZ, U_F_SET, U_WR_HDR, U_WR_FTR, U_WR_EPI,
		U_LAY0, U_LAY1, U_LAY2, U_LAY3, U_GSZ_CHUNK, U_GSZ_EXT, U_GROW0,
		U_M0, U_M1, U_M2, U_M3, U_M4, U_M5, U_MA0, U_MB0, U_MB1, U_MC0, U_MC1,
		U_ROV, U_S_INIT, U_S_RD, U_S_EV, U_P_RD, U_P_EV, U_P_S1, U_P_S2, U_P_S3,
		U_P_W1, U_OUT_FREE, U_OUT_ZERO, U_OUT_OOM, U_OUT_BP
	} uop_t;

	typedef struct packed {
		uop_t uop;
	} cmd_t;

	typedef struct packed {
		logic op_free;
		logic addr_null;
		logic init;
		logic req_zero;
		logic gfail;
		logic pa;
		logic na;
		logic s_found;
		logic s_end;
		logic phase;
		logic split;
		logic out_busy;
	} stat_t;

endpackage

`default_nettype wire

// File: rtl/next_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// next_fit_heap_allocator_core
// next-fit boundary-tag heap allocator with coalescing free
// ----------------------------------------------------------------------------
//   channel  dir  beat contents
//   s_*      in   tuser operation, tdata request_bytes / block_address
//   m_*      out  tdata result_address / status
//   cfg_*    in   chunk_bytes
//
// one item at a time; a beat is taken only while the sequencer is idle
// allocate: a search that walks the block headers, plus a heap grow when
//   no block fits; free: a footer write and a merge with its neighbours
// each header visit costs one registered read of the tag memory port
// the first request, unless it is a null free, lays out the heap first
// reset clears control only; the tag memory needs no clearing pass
// a result waits in the output register while m_tready is low
// ----------------------------------------------------------------------------
`default_nettype none

`include "next_fit_heap_allocator_core_macros.svh"

module next_fit_heap_allocator_core #(
	parameter int HEAP_BYTES = 65536
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // request_bytes [15:0], block_address [31:16]
	input  wire         s_tuser,   // operation [0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // result_address [15:0], status [17:16], zeros above
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [16:0] cfg_data
);

	nfa_pkg::cmd_t  cmd;
	nfa_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	nfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	nfa_datapath #(
		.HEAP_BYTES (HEAP_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	`NFA_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "second beat taken while busy")
	`NFA_ASSERT_NOW(a_status_code, clk, arst_n, m_tvalid, m_tdata[17:16] != 2'b11, "bad status code")
	`NFA_ASSERT_NOW(a_addr_ok, clk, arst_n, m_tvalid && m_tdata[15:0] != 16'd0, m_tdata[17:16] == nfa_pkg::ST_OK, "address with failure status")
	`NFA_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.uop == nfa_pkg::U_OUT_FREE || cmd.uop == nfa_pkg::U_OUT_ZERO || cmd.uop == nfa_pkg::U_OUT_OOM || cmd.uop == nfa_pkg::U_OUT_BP, !(m_tvalid && !m_tready), "result overwritten")

endmodule

`default_nettype wire

// File: rtl/nfa_datapath.sv
// ----------------------------------------------------------------------------
// nfa_datapath
// tag memory, heap registers and address arithmetic driven by micro-ops
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_datapath #(
	parameter int HEAP_BYTES = 65536
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  nfa_pkg::cmd_t       cmd,
	output nfa_pkg::stat_t      stat,
	input  wire                 s_tuser,
	input  wire  [31:0]         s_tdata,
	input  wire                 cfg_valid,
	input  wire  [16:0]         cfg_data,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [23:0]         m_tdata
);

	localparam int WORDS = HEAP_BYTES / 4;
	localparam int IW    = $clog2(WORDS);
	localparam int TW    = $clog2(HEAP_BYTES) + 1;
	localparam int AW    = ($clog2(HEAP_BYTES) + 3 > 19) ? $clog2(HEAP_BYTES) + 3 : 19;

	typedef logic [AW-1:0] addr_t;

	logic [TW-1:0] mem [WORDS];
	logic [TW-1:0] rd_q;
	logic          oob_q;

	logic          op_q;
	logic [15:0]   req_q;
	logic [15:0]   addr_q;
	logic [16:0]   chunk_q;
	logic          init_q;
	addr_t         rover_q, heap_end_q;
	addr_t         start_q, bp_q, sz_q, fsz_q, gsz_q, prev_q, phsz_q, nsz_q, nfsz_q;
	addr_t         aux_q, csz_q;
	logic          phase_q, pa_q, na_q;
	logic          out_valid_q;
	logic [15:0]   out_addr_q;
	logic [1:0]    out_st_q;

	logic          rd_en, we;
	addr_t         raddr, waddr, wdata;
	addr_t         rdv, size_rd, asz, effc, ext, grown_end;
	logic          s_cond, s_fits;

	function automatic addr_t even_words(input addr_t b);
		even_words = ((b & ~addr_t'(3)) + addr_t'(nfa_pkg::WORD_BYTES))
			& ~addr_t'(nfa_pkg::FLAG_BITS);
	endfunction

	assign rdv     = oob_q ? '0 : addr_t'(rd_q);
	assign size_rd = rdv & ~addr_t'(nfa_pkg::FLAG_BITS);
	assign asz     = (req_q <= 16'(nfa_pkg::DWORD_BYTES)) ? addr_t'(nfa_pkg::MIN_BLOCK)
		: (addr_t'(req_q) + addr_t'(15)) & ~addr_t'(nfa_pkg::FLAG_BITS);
	assign effc    = (chunk_q < 17'(nfa_pkg::MIN_CHUNK)) ? addr_t'(nfa_pkg::MIN_CHUNK)
		: addr_t'(chunk_q);
	assign ext       = (asz > effc) ? asz : effc;
	assign grown_end = heap_end_q + gsz_q;

	// search loop test on the header just read
	assign s_cond = (rover_q < heap_end_q) && (size_rd != '0) && (!phase_q || rover_q < start_q);
	assign s_fits = !rdv[0] && (asz <= size_rd);

	always_comb begin
		stat.op_free   = op_q;
		stat.addr_null = (addr_q == 16'd0);
		stat.init      = init_q;
		stat.req_zero  = (req_q == 16'd0);
		stat.gfail     = grown_end > addr_t'(HEAP_BYTES);
		stat.pa        = pa_q;
		stat.na        = na_q;
		stat.s_found   = s_cond && s_fits;
		stat.s_end     = !s_cond;
		stat.phase     = phase_q;
		stat.split     = size_rd >= asz + addr_t'(nfa_pkg::MIN_BLOCK);
		stat.out_busy  = out_valid_q && !m_tready;
	end

	always_comb begin
		rd_en = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		case (cmd.uop)
			nfa_pkg::U_F_RD: begin
				rd_en = 1'b1; raddr = addr_t'(addr_q) - addr_t'(nfa_pkg::WORD_BYTES);
			end
			nfa_pkg::U_F_SET: begin
				we = 1'b1; waddr = addr_t'(addr_q) - addr_t'(nfa_pkg::WORD_BYTES); wdata = fsz_q;
			end
			nfa_pkg::U_WR_HDR: begin
				we = 1'b1; waddr = bp_q - addr_t'(nfa_pkg::WORD_BYTES); wdata = sz_q;
			end
			nfa_pkg::U_WR_FTR: begin
				we = 1'b1; waddr = bp_q + sz_q - addr_t'(nfa_pkg::DWORD_BYTES); wdata = sz_q;
			end
			nfa_pkg::U_WR_EPI: begin
				we = 1'b1; waddr = bp_q + sz_q - addr_t'(nfa_pkg::WORD_BYTES);
				wdata = addr_t'(nfa_pkg::EPI_TAG);
			end
			nfa_pkg::U_LAY0: begin
				we = 1'b1; waddr = '0; wdata = '0;
			end
			nfa_pkg::U_LAY1: begin
				we = 1'b1; waddr = addr_t'(4); wdata = addr_t'(nfa_pkg::PRO_TAG);
			end
			nfa_pkg::U_LAY2: begin
				we = 1'b1; waddr = addr_t'(8); wdata = addr_t'(nfa_pkg::PRO_TAG);
			end
			nfa_pkg::U_LAY3: begin
				we = 1'b1; waddr = addr_t'(12); wdata = addr_t'(nfa_pkg::EPI_TAG);
			end
			nfa_pkg::U_M0: begin
				rd_en = 1'b1; raddr = bp_q - addr_t'(nfa_pkg::DWORD_BYTES);
			end
			nfa_pkg::U_M1: begin
				rd_en = 1'b1; raddr = bp_q - size_rd - addr_t'(nfa_pkg::WORD_BYTES);
			end
			nfa_pkg::U_M2: begin
				rd_en = 1'b1; raddr = prev_q + size_rd - addr_t'(nfa_pkg::DWORD_BYTES);
			end
			nfa_pkg::U_M3: begin
				rd_en = 1'b1; raddr = bp_q + sz_q - addr_t'(nfa_pkg::WORD_BYTES);
			end
			nfa_pkg::U_M4: begin
				rd_en = 1'b1; raddr = bp_q + sz_q + size_rd - addr_t'(nfa_pkg::DWORD_BYTES);
			end
			nfa_pkg::U_MA0: begin
				we = 1'b1; waddr = bp_q - addr_t'(nfa_pkg::WORD_BYTES); wdata = sz_q + nsz_q;
			end
			nfa_pkg::U_MB0: begin
				we = 1'b1; waddr = bp_q + sz_q - addr_t'(nfa_pkg::DWORD_BYTES);
				wdata = sz_q + phsz_q;
			end
			nfa_pkg::U_MB1: begin
				we = 1'b1; waddr = prev_q - addr_t'(nfa_pkg::WORD_BYTES); wdata = sz_q;
			end
			nfa_pkg::U_MC0: begin
				we = 1'b1; waddr = prev_q - addr_t'(nfa_pkg::WORD_BYTES);
				wdata = sz_q + phsz_q + nfsz_q;
			end
			nfa_pkg::U_MC1: begin
				we = 1'b1; waddr = aux_q; wdata = sz_q;
			end
			nfa_pkg::U_S_RD: begin
				rd_en = 1'b1; raddr = rover_q - addr_t'(nfa_pkg::WORD_BYTES);
			end
			nfa_pkg::U_P_RD: begin
				rd_en = 1'b1; raddr = bp_q - addr_t'(nfa_pkg::WORD_BYTES);
			end
			nfa_pkg::U_P_EV: begin
				we = 1'b1; waddr = bp_q - addr_t'(nfa_pkg::WORD_BYTES);
				wdata = stat.split ? (asz | addr_t'(1)) : (size_rd | addr_t'(1));
			end
			nfa_pkg::U_P_S1: begin
				we = 1'b1; waddr = bp_q + asz - addr_t'(nfa_pkg::DWORD_BYTES);
				wdata = asz | addr_t'(1);
			end
			nfa_pkg::U_P_S2: begin
				we = 1'b1; waddr = bp_q + asz - addr_t'(nfa_pkg::WORD_BYTES); wdata = csz_q - asz;
			end
			nfa_pkg::U_P_S3: begin
				we = 1'b1; waddr = bp_q + csz_q - addr_t'(nfa_pkg::DWORD_BYTES);
				wdata = csz_q - asz;
			end
			nfa_pkg::U_P_W1: begin
				we = 1'b1; waddr = bp_q + csz_q - addr_t'(nfa_pkg::DWORD_BYTES);
				wdata = csz_q | addr_t'(1);
			end
			default: begin
			end
		endcase
	end

	// tag memory, registered read, accesses past the heap read zero and drop writes
	always_ff @(posedge clk) begin
		if (we && waddr < addr_t'(HEAP_BYTES)) begin
			mem[waddr[IW+1:2]] <= wdata[TW-1:0];
		end
		if (rd_en) begin
			oob_q <= raddr >= addr_t'(HEAP_BYTES);
			if (raddr < addr_t'(HEAP_BYTES)) begin
				rd_q <= mem[raddr[IW+1:2]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q     <= 17'd4096;
			init_q      <= 1'b0;
			rover_q     <= '0;
			heap_end_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				chunk_q <= cfg_data;
			end
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.uop)
				nfa_pkg::U_LAY0: begin
					heap_end_q <= addr_t'(nfa_pkg::LAYOUT_END);
					init_q     <= 1'b1;
					rover_q    <= addr_t'(nfa_pkg::FIRST_BP);
				end
				nfa_pkg::U_GROW0: heap_end_q <= grown_end;
				nfa_pkg::U_ROV: begin
					if (rover_q > bp_q && rover_q < bp_q + sz_q) begin
						rover_q <= bp_q;
					end
				end
				nfa_pkg::U_S_EV: begin
					if (!stat.s_found) begin
						if (stat.s_end) begin
							if (!phase_q) begin
								rover_q <= addr_t'(nfa_pkg::FIRST_BP);
							end
						end else begin
							rover_q <= rover_q + size_rd;
						end
					end
				end
				nfa_pkg::U_OUT_FREE, nfa_pkg::U_OUT_ZERO, nfa_pkg::U_OUT_OOM,
				nfa_pkg::U_OUT_BP: out_valid_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.uop)
			nfa_pkg::U_ACCEPT: begin
				op_q   <= s_tuser;
				req_q  <= s_tdata[15:0];
				addr_q <= s_tdata[31:16];
			end
			nfa_pkg::U_F_SZ: fsz_q <= size_rd;
			nfa_pkg::U_F_SET: begin
				bp_q <= addr_t'(addr_q);
				sz_q <= fsz_q;
			end
			nfa_pkg::U_GSZ_CHUNK: gsz_q <= even_words(effc);
			nfa_pkg::U_GSZ_EXT:   gsz_q <= even_words(ext);
			nfa_pkg::U_GROW0: begin
				bp_q <= heap_end_q;
				sz_q <= gsz_q;
			end
			nfa_pkg::U_M1: prev_q <= bp_q - size_rd;
			nfa_pkg::U_M2: phsz_q <= size_rd;
			nfa_pkg::U_M3: pa_q <= rdv[0];
			nfa_pkg::U_M4: begin
				na_q  <= rdv[0];
				nsz_q <= size_rd;
			end
			nfa_pkg::U_M5: nfsz_q <= size_rd;
			nfa_pkg::U_MA0: sz_q <= sz_q + nsz_q;
			nfa_pkg::U_MB0: sz_q <= sz_q + phsz_q;
			nfa_pkg::U_MB1: bp_q <= prev_q;
			nfa_pkg::U_MC0: begin
				sz_q  <= sz_q + phsz_q + nfsz_q;
				aux_q <= bp_q + sz_q + nsz_q - addr_t'(nfa_pkg::DWORD_BYTES);
			end
			nfa_pkg::U_MC1: bp_q <= prev_q;
			nfa_pkg::U_S_INIT: begin
				start_q <= rover_q;
				phase_q <= 1'b0;
			end
			nfa_pkg::U_S_EV: begin
				if (stat.s_found) begin
					bp_q <= rover_q;
				end else if (stat.s_end) begin
					phase_q <= 1'b1;
				end
			end
			nfa_pkg::U_P_EV: csz_q <= size_rd;
			nfa_pkg::U_OUT_FREE: begin
				out_addr_q <= '0; out_st_q <= nfa_pkg::ST_OK;
			end
			nfa_pkg::U_OUT_ZERO: begin
				out_addr_q <= '0; out_st_q <= nfa_pkg::ST_ZERO;
			end
			nfa_pkg::U_OUT_OOM: begin
				out_addr_q <= '0; out_st_q <= nfa_pkg::ST_OOM;
			end
			nfa_pkg::U_OUT_BP: begin
				out_addr_q <= bp_q[15:0]; out_st_q <= nfa_pkg::ST_OK;
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_st_q, out_addr_q};

endmodule

`default_nettype wire

// File: rtl/nfa_ctrl.sv
// ----------------------------------------------------------------------------
// nfa_ctrl
// sequencer for layout, search, grow, merge and placement
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            s_tvalid,
	output logic           s_tready,
	input  nfa_pkg::stat_t stat,
	output nfa_pkg::cmd_t  cmd
);

	typedef enum logic [43:0] {
		S_IDLE   = 44'd1 << 0,  S_DISP   = 44'd1 << 1,  S_F_RD   = 44'd1 << 2,
		S_F_SZ   = 44'd1 << 3,  S_F_SET  = 44'd1 << 4,  S_F_WF   = 44'd1 << 5,
		S_LAY0   = 44'd1 << 6,  S_LAY1   = 44'd1 << 7,  S_LAY2   = 44'd1 << 8,
		S_LAY3   = 44'd1 << 9,  S_LAY_G  = 44'd1 << 10, S_A_CHK  = 44'd1 << 11,
		S_A_GSZ  = 44'd1 << 12, S_G_CHK  = 44'd1 << 13, S_G_0    = 44'd1 << 14,
		S_G_WH   = 44'd1 << 15, S_G_WF   = 44'd1 << 16, S_G_WE   = 44'd1 << 17,
		S_M_0    = 44'd1 << 18, S_M_1    = 44'd1 << 19, S_M_2    = 44'd1 << 20,
		S_M_3    = 44'd1 << 21, S_M_4    = 44'd1 << 22, S_M_5    = 44'd1 << 23,
		S_M_A0   = 44'd1 << 24, S_M_A1   = 44'd1 << 25, S_M_B0   = 44'd1 << 26,
		S_M_B1   = 44'd1 << 27, S_M_C0   = 44'd1 << 28, S_M_C1   = 44'd1 << 29,
		S_M_ROV  = 44'd1 << 30, S_S_INIT = 44'd1 << 31, S_S_RD   = 44'd1 << 32,
		S_S_EV   = 44'd1 << 33, S_P_RD   = 44'd1 << 34, S_P_EV   = 44'd1 << 35,
		S_P_S1   = 44'd1 << 36, S_P_S2   = 44'd1 << 37, S_P_S3   = 44'd1 << 38,
		S_P_W1   = 44'd1 << 39, S_O_FREE = 44'd1 << 40, S_O_ZERO = 44'd1 << 41,
		S_O_OOM  = 44'd1 << 42, S_O_BP   = 44'd1 << 43
	} state_t;

	state_t state_q, state_d;
	logic   in_grow_q, in_grow_d, in_layout_q, in_layout_d;
	state_t lay_ret, merge_ret;

	assign lay_ret = stat.op_free ? S_F_SET : S_A_CHK;

	always_comb begin
		if (!in_grow_q) begin
			merge_ret = S_O_FREE;
		end else if (in_layout_q) begin
			merge_ret = lay_ret;
		end else begin
			merge_ret = S_P_RD;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_grow_d   = in_grow_q;
		in_layout_d = in_layout_q;
		cmd.uop     = nfa_pkg::U_NOP;
		s_tready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.uop     = nfa_pkg::U_ACCEPT;
					in_grow_d   = 1'b0;
					in_layout_d = 1'b0;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.op_free) begin
					state_d = S_F_RD;
				end else begin
					state_d = stat.init ? S_A_CHK : S_LAY0;
				end
			end
			S_F_RD: begin
				if (stat.addr_null) begin
					state_d = S_O_FREE;
				end else begin
					cmd.uop = nfa_pkg::U_F_RD;
					state_d = S_F_SZ;
				end
			end
			S_F_SZ: begin
				cmd.uop = nfa_pkg::U_F_SZ;
				state_d = stat.init ? S_F_SET : S_LAY0;
			end
			S_F_SET: begin
				cmd.uop = nfa_pkg::U_F_SET;
				state_d = S_F_WF;
			end
			S_F_WF: begin
				cmd.uop = nfa_pkg::U_WR_FTR;
				state_d = S_M_0;
			end
			S_LAY0: begin
				cmd.uop     = nfa_pkg::U_LAY0;
				in_layout_d = 1'b1;
				state_d     = S_LAY1;
			end
			S_LAY1: begin
				cmd.uop = nfa_pkg::U_LAY1;
				state_d = S_LAY2;
			end
			S_LAY2: begin
				cmd.uop = nfa_pkg::U_LAY2;
				state_d = S_LAY3;
			end
			S_LAY3: begin
				cmd.uop = nfa_pkg::U_LAY3;
				state_d = S_LAY_G;
			end
			S_LAY_G: begin
				cmd.uop   = nfa_pkg::U_GSZ_CHUNK;
				in_grow_d = 1'b1;
				state_d   = S_G_CHK;
			end
			S_A_CHK: begin
				state_d = stat.req_zero ? S_O_ZERO : S_S_INIT;
			end
			S_A_GSZ: begin
				cmd.uop   = nfa_pkg::U_GSZ_EXT;
				in_grow_d = 1'b1;
				state_d   = S_G_CHK;
			end
			S_G_CHK: begin
				if (stat.gfail) begin
					in_grow_d   = 1'b0;
					in_layout_d = 1'b0;
					state_d     = in_layout_q ? lay_ret : S_O_OOM;
				end else begin
					state_d = S_G_0;
				end
			end
			S_G_0: begin
				cmd.uop = nfa_pkg::U_GROW0;
				state_d = S_G_WH;
			end
			S_G_WH: begin
				cmd.uop = nfa_pkg::U_WR_HDR;
				state_d = S_G_WF;
			end
			S_G_WF: begin
				cmd.uop = nfa_pkg::U_WR_FTR;
				state_d = S_G_WE;
			end
			S_G_WE: begin
				cmd.uop = nfa_pkg::U_WR_EPI;
				state_d = S_M_0;
			end
			S_M_0: begin
				cmd.uop = nfa_pkg::U_M0;
				state_d = S_M_1;
			end
			S_M_1: begin
				cmd.uop = nfa_pkg::U_M1;
				state_d = S_M_2;
			end
			S_M_2: begin
				cmd.uop = nfa_pkg::U_M2;
				state_d = S_M_3;
			end
			S_M_3: begin
				cmd.uop = nfa_pkg::U_M3;
				state_d = S_M_4;
			end
			S_M_4: begin
				cmd.uop = nfa_pkg::U_M4;
				state_d = S_M_5;
			end
			S_M_5: begin
				cmd.uop = nfa_pkg::U_M5;
				// four coalescing cases
				if (stat.pa && stat.na) begin
					in_grow_d   = 1'b0;
					in_layout_d = 1'b0;
					state_d     = merge_ret;
				end else if (stat.pa) begin
					state_d = S_M_A0;
				end else if (stat.na) begin
					state_d = S_M_B0;
				end else begin
					state_d = S_M_C0;
				end
			end
			S_M_A0: begin
				cmd.uop = nfa_pkg::U_MA0;
				state_d = S_M_A1;
			end
			S_M_A1: begin
				cmd.uop = nfa_pkg::U_WR_FTR;
				state_d = S_M_ROV;
			end
			S_M_B0: begin
				cmd.uop = nfa_pkg::U_MB0;
				state_d = S_M_B1;
			end
			S_M_B1: begin
				cmd.uop = nfa_pkg::U_MB1;
				state_d = S_M_ROV;
			end
			S_M_C0: begin
				cmd.uop = nfa_pkg::U_MC0;
				state_d = S_M_C1;
			end
			S_M_C1: begin
				cmd.uop = nfa_pkg::U_MC1;
				state_d = S_M_ROV;
			end
			S_M_ROV: begin
				cmd.uop     = nfa_pkg::U_ROV;
				in_grow_d   = 1'b0;
				in_layout_d = 1'b0;
				state_d     = merge_ret;
			end
			S_S_INIT: begin
				cmd.uop = nfa_pkg::U_S_INIT;
				state_d = S_S_RD;
			end
			S_S_RD: begin
				cmd.uop = nfa_pkg::U_S_RD;
				state_d = S_S_EV;
			end
			S_S_EV: begin
				cmd.uop = nfa_pkg::U_S_EV;
				if (stat.s_found) begin
					state_d = S_P_RD;
				end else if (stat.s_end && stat.phase) begin
					state_d = S_A_GSZ;
				end else begin
					state_d = S_S_RD;
				end
			end
			S_P_RD: begin
				cmd.uop = nfa_pkg::U_P_RD;
				state_d = S_P_EV;
			end
			S_P_EV: begin
				cmd.uop = nfa_pkg::U_P_EV;
				state_d = stat.split ? S_P_S1 : S_P_W1;
			end
			S_P_S1: begin
				cmd.uop = nfa_pkg::U_P_S1;
				state_d = S_P_S2;
			end
			S_P_S2: begin
				cmd.uop = nfa_pkg::U_P_S2;
				state_d = S_P_S3;
			end
			S_P_S3: begin
				cmd.uop = nfa_pkg::U_P_S3;
				state_d = S_O_BP;
			end
			S_P_W1: begin
				cmd.uop = nfa_pkg::U_P_W1;
				state_d = S_O_BP;
			end
			S_O_FREE: begin
				if (!stat.out_busy) begin
					cmd.uop = nfa_pkg::U_OUT_FREE;
					state_d = S_IDLE;
				end
			end
			S_O_ZERO: begin
				if (!stat.out_busy) begin
					cmd.uop = nfa_pkg::U_OUT_ZERO;
					state_d = S_IDLE;
				end
			end
			S_O_OOM: begin
				if (!stat.out_busy) begin
					cmd.uop = nfa_pkg::U_OUT_OOM;
					state_d = S_IDLE;
				end
			end
			S_O_BP: begin
				if (!stat.out_busy) begin
					cmd.uop = nfa_pkg::U_OUT_BP;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_grow_q   <= 1'b0;
			in_layout_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			in_grow_q   <= in_grow_d;
			in_layout_q <= in_layout_d;
		end
	end

endmodule

`default_nettype wire

// File: bench/next_fit_heap_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// next_fit_heap_allocator_core_tb
// self-checking bench for the next-fit boundary-tag heap allocator
// ----------------------------------------------------------------------------
// a shadow heap predicts every reply as each request beat is taken. Frees only
// name blocks that the shadow heap holds as allocated, so no tag word is read
// before it has been written. The run starts with directed requests: null
// free, zero size, a failed first layout, out of memory and three of the four
// merge cases of a free. After that it sends random alloc/free traffic in
// phases, each with its own chunk size and its own mix of source idling and
// sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module next_fit_heap_allocator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nfa_pkg::*;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;
	localparam int   TAG_WORDS = 16384;
	localparam int   HEAP_SIZE = 65536;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic        op;
		logic [15:0] req_bytes;
		logic [15:0] blk_addr;
	} heap_req_t;

	typedef struct {
		logic [15:0] addr;
		logic [1:0]  status;
	} heap_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data = '0;

	next_fit_heap_allocator_core #(.HEAP_BYTES(HEAP_SIZE)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	heap_req_t   pending_reqs[$];
	heap_reply_t expected_replies[$];
	logic [15:0] live_blocks[$];

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int mismatches = 0;
	int replies_seen = 0;
	int grants = 0;
	int oom_count = 0;
	int zero_count = 0;
	int frees_sent = 0;
	longint cycles = 0;

	// shadow heap
	bit [31:0]   shadow_tags[TAG_WORDS];
	bit [63:0]   rover_bp;
	bit [63:0]   heap_top;
	bit          heap_laid;
	logic [16:0] chunk_reg = 17'd4096;

	function automatic bit [63:0] tag_read(bit [63:0] a);
		if ((a >> 2) >= TAG_WORDS)
			return 0;
		return shadow_tags[a >> 2];
	endfunction

	function automatic void tag_write(bit [63:0] a, bit [63:0] v);
		if ((a >> 2) < TAG_WORDS)
			shadow_tags[a >> 2] = v[31:0];
	endfunction

	function automatic bit [63:0] blk_size(bit [63:0] a);
		return tag_read(a) & ~64'd7;
	endfunction

	function automatic bit blk_used(bit [63:0] a);
		return tag_read(a) & 64'd1;
	endfunction

	function automatic bit [63:0] foot_of(bit [63:0] bp);
		return bp + blk_size(bp - 4) - 8;
	endfunction

	function automatic bit [63:0] next_of(bit [63:0] bp);
		return bp + blk_size(bp - 4);
	endfunction

	function automatic bit [63:0] prev_of(bit [63:0] bp);
		return bp - blk_size(bp - 8);
	endfunction

	function automatic bit [63:0] coalesce(bit [63:0] bp);
		bit pa, na;
		bit [63:0] s;
		pa = blk_used(foot_of(prev_of(bp)));
		na = blk_used(next_of(bp) - 4);
		s = blk_size(bp - 4);
		if (pa && na)
			return bp;
		if (pa && !na) begin
			s += blk_size(next_of(bp) - 4);
			tag_write(bp - 4, s);
			tag_write(foot_of(bp), s);
		end else if (!pa && na) begin
			s += blk_size(prev_of(bp) - 4);
			tag_write(foot_of(bp), s);
			tag_write(prev_of(bp) - 4, s);
			bp = prev_of(bp);
		end else begin
			s += blk_size(prev_of(bp) - 4) + blk_size(foot_of(next_of(bp)));
			tag_write(prev_of(bp) - 4, s);
			tag_write(foot_of(next_of(bp)), s);
			bp = prev_of(bp);
		end
		if (rover_bp > bp && rover_bp < next_of(bp))
			rover_bp = bp;
		return bp;
	endfunction

	function automatic bit [63:0] extend_heap(bit [63:0] words);
		bit [63:0] s, bp;
		s = (words[0] ? words + 1 : words) * 4;
		bp = heap_top;
		if (heap_top + s > HEAP_SIZE)
			return 0;
		heap_top += s;
		tag_write(bp - 4, s);
		tag_write(foot_of(bp), s);
		tag_write(next_of(bp) - 4, 1);
		return coalesce(bp);
	endfunction

	function automatic bit [63:0] chunk_eff();
		return (chunk_reg < 8) ? 64'd8 : 64'(chunk_reg);
	endfunction

	function automatic void lay_out_heap();
		bit [63:0] dummy;
		heap_top = LAYOUT_END;
		tag_write(0, 0);
		tag_write(4, PRO_TAG);
		tag_write(8, PRO_TAG);
		tag_write(12, EPI_TAG);
		heap_laid = 1'b1;
		rover_bp = FIRST_BP;
		dummy = extend_heap(chunk_eff() / 4);
	endfunction

	function automatic bit fits(bit [63:0] bp, bit [63:0] asz);
		return !blk_used(bp - 4) && asz <= blk_size(bp - 4);
	endfunction

	function automatic bit [63:0] find_fit(bit [63:0] asz);
		bit [63:0] start;
		start = rover_bp;
		for (; rover_bp < heap_top && blk_size(rover_bp - 4) > 0; rover_bp = next_of(rover_bp))
			if (fits(rover_bp, asz))
				return rover_bp;
		for (rover_bp = FIRST_BP; rover_bp < start && rover_bp < heap_top
				&& blk_size(rover_bp - 4) > 0; rover_bp = next_of(rover_bp))
			if (fits(rover_bp, asz))
				return rover_bp;
		return 0;
	endfunction

	function automatic void carve(bit [63:0] bp, bit [63:0] asz);
		bit [63:0] csz;
		csz = blk_size(bp - 4);
		if (csz >= asz + MIN_BLOCK) begin
			tag_write(bp - 4, asz | 1);
			tag_write(foot_of(bp), asz | 1);
			bp = next_of(bp);
			tag_write(bp - 4, csz - asz);
			tag_write(foot_of(bp), csz - asz);
		end else begin
			tag_write(bp - 4, csz | 1);
			tag_write(foot_of(bp), csz | 1);
		end
	endfunction

	function automatic heap_reply_t predict_heap_op(heap_req_t r);
		heap_reply_t rep;
		bit [63:0] s, asz, bp;
		rep.addr = '0;
		rep.status = ST_OK;
		if (r.op == OP_FREE) begin
			if (r.blk_addr != 0) begin
				s = blk_size(64'(r.blk_addr) - 4);
				if (!heap_laid)
					lay_out_heap();
				tag_write(64'(r.blk_addr) - 4, s);
				tag_write(foot_of(64'(r.blk_addr)), s);
				bp = coalesce(64'(r.blk_addr));
			end
			return rep;
		end
		if (!heap_laid)
			lay_out_heap();
		if (r.req_bytes == 0) begin
			rep.status = ST_ZERO;
			return rep;
		end
		asz = (r.req_bytes <= DWORD_BYTES) ? 64'(MIN_BLOCK)
			: 8 * ((64'(r.req_bytes) + 15) / 8);
		bp = find_fit(asz);
		if (bp == 0) begin
			bp = extend_heap((asz > chunk_eff() ? asz : chunk_eff()) / 4);
			if (bp == 0) begin
				rep.status = ST_OOM;
				return rep;
			end
		end
		carve(bp, asz);
		rep.addr = bp[15:0];
		return rep;
	endfunction

	// source side: take beats, predict, then offer the next one
	always @(posedge clk) begin
		heap_reply_t rep;
		bit go;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				rep = predict_heap_op(pending_reqs[0]);
				expected_replies.push_back(rep);
				if (pending_reqs[0].op == OP_ALLOC && rep.status == ST_OK)
					live_blocks.push_back(rep.addr);
				pending_reqs.pop_front();
			end
			if (!(s_tvalid && !s_tready)) begin
				go = pending_reqs.size() > 0 && $urandom_range(0, 99) >= src_idle_pct;
				s_tvalid <= go;
				if (go) begin
					s_tdata <= {pending_reqs[0].blk_addr, pending_reqs[0].req_bytes};
					s_tuser <= pending_reqs[0].op;
				end
			end
		end
	end

	// sink side
	always @(posedge clk) begin
		heap_reply_t want;
		if (arst_n) begin
			m_tready <= $urandom_range(0, 99) >= snk_stall_pct;
			if (m_tvalid && m_tready) begin
				replies_seen++;
				if (expected_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected reply beat %h", m_tdata);
				end else begin
					want = expected_replies.pop_front();
					if (m_tdata[15:0] !== want.addr || m_tdata[17:16] !== want.status
							|| m_tdata[23:18] !== '0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("reply %0d: expected addr %h status %0d, got addr %h status %0d raw %h",
								replies_seen, want.addr, want.status,
								m_tdata[15:0], m_tdata[17:16], m_tdata);
					end
					if (want.status == ST_OK && want.addr != 0)
						grants++;
					if (want.status == ST_OOM)
						oom_count++;
					if (want.status == ST_ZERO)
						zero_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic push_req(logic op, logic [15:0] req, logic [15:0] addr);
		heap_req_t r;
		while (pending_reqs.size() >= 4)
			@(posedge clk);
		r.op = op;
		r.req_bytes = req;
		r.blk_addr = addr;
		pending_reqs.push_back(r);
		if (op == OP_FREE)
			frees_sent++;
	endtask

	task automatic wait_sent();
		while (pending_reqs.size() > 0 || s_tvalid)
			@(posedge clk);
	endtask

	// quiesce: wait until every request is sent and every expected reply has come back
	task automatic wait_idle();
		wait_sent();
		while (expected_replies.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_chunk(logic [16:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		chunk_reg = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic free_random();
		int k;
		logic [15:0] a;
		k = $urandom_range(0, live_blocks.size() - 1);
		a = live_blocks[k];
		live_blocks.delete(k);
		push_req(OP_FREE, 16'd0, a);
	endtask

	task automatic random_item();
		int r;
		logic [15:0] req;
		r = $urandom_range(0, 99);
		if (r < 3)
			push_req(OP_FREE, $urandom(), 16'd0);
		else if (r < 6)
			push_req(OP_ALLOC, 16'd0, $urandom());
		else if (live_blocks.size() > 0 && (r < 48 || live_blocks.size() > 80))
			free_random();
		else begin
			r = $urandom_range(0, 99);
			if (r < 70)
				req = $urandom_range(1, 64);
			else if (r < 90)
				req = $urandom_range(1, 1024);
			else if (r < 98)
				req = $urandom_range(1, 8192);
			else
				req = $urandom_range(1, 65535);
			push_req(OP_ALLOC, req, $urandom());
		end
	endtask

	initial begin
		int phase_src[4] = '{0, 64, 0, 29};
		int phase_snk[4] = '{0, 0, 64, 29};
		logic [16:0] phase_chunk[4];
		logic [15:0] a1, a2, a3, a4;
		int n;

		for (int i = 0; i < TAG_WORDS; i++)
			shadow_tags[i] = 0;
		rover_bp = 0;
		heap_top = 0;
		heap_laid = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first layout cannot fit a full-heap chunk, heap stays a skeleton
		write_chunk(17'd65536);
		push_req(OP_FREE, 16'hFFFF, 16'd0);
		push_req(OP_ALLOC, 16'd0, 16'hFFFF);
		wait_idle();
		write_chunk(17'd0);
		push_req(OP_ALLOC, 16'd1, 16'd0);
		push_req(OP_ALLOC, 16'd8, 16'd0);
		push_req(OP_ALLOC, 16'd9, 16'd0);
		push_req(OP_ALLOC, 16'hFFFF, 16'd0);
		wait_idle();
		write_chunk(17'd4096);
		push_req(OP_ALLOC, 16'd24, 16'd0);
		push_req(OP_ALLOC, 16'd24, 16'd0);
		push_req(OP_ALLOC, 16'd24, 16'd0);
		push_req(OP_ALLOC, 16'd24, 16'd0);
		wait_sent();
		n = live_blocks.size();
		a1 = live_blocks[n-4];
		a2 = live_blocks[n-3];
		a3 = live_blocks[n-2];
		a4 = live_blocks[n-1];
		repeat (4) live_blocks.pop_back();
		// both neighbors used, next free, both free, next free again
		push_req(OP_FREE, 16'd0, a2);
		push_req(OP_FREE, 16'd0, a4);
		push_req(OP_FREE, 16'd0, a3);
		push_req(OP_FREE, 16'd0, a1);
		push_req(OP_ALLOC, 16'd40000, 16'd0);
		push_req(OP_ALLOC, 16'd30000, 16'd0);
		wait_idle();

		phase_chunk[0] = 17'd4096;
		phase_chunk[1] = 17'd8;
		phase_chunk[2] = 17'd65536;
		phase_chunk[3] = 17'($urandom_range(8, 65536));
		for (int p = 0; p < 4; p++) begin
			wait_idle();
			write_chunk(phase_chunk[p]);
			src_idle_pct = phase_src[p];
			snk_stall_pct = phase_snk[p];
			for (int i = 0; i < 500; i++)
				random_item();
		end
		// odd chunk value that is not a whole number of dwords
		wait_idle();
		write_chunk(17'd1);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		for (int i = 0; i < 40; i++)
			random_item();

		wait_idle();
		repeat (200) @(posedge clk);
		mismatches += expected_replies.size();
		$display("%0d replies checked: %0d grants, %0d out of memory, %0d zero size, %0d frees",
			replies_seen, grants, oom_count, zero_count, frees_sent);
		$display("chunk sizes from the minimum to the whole heap, %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
